>>> src/uart_buffered_rx_tx_rings_assert.svh
// Assertion macros for the buffered serial terminal.
// Included by the top level; needs nothing else.
`ifndef UART_BUFFERED_RX_TX_RINGS_ASSERT_SVH
`define UART_BUFFERED_RX_TX_RINGS_ASSERT_SVH

// Implication checked in the same cycle.
`define UBRT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication checked in the cycle after the antecedent.
`define UBRT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/ubrt_pkg.sv
// Shared types and codes of the buffered serial terminal.
// Used by the control unit and the top level; depends on nothing.
package ubrt_pkg;

   localparam logic [1:0] MODE_HOST_WRITE = 2'd0;
   localparam logic [1:0] MODE_HOST_READ  = 2'd1;
   localparam logic [1:0] MODE_LINE_RX    = 2'd2;
   localparam logic [1:0] MODE_TX_TICK    = 2'd3;

   localparam logic [1:0] TXS_EMPTY  = 2'd0;
   localparam logic [1:0] TXS_NORMAL = 2'd1;
   localparam logic [1:0] TXS_FULL   = 2'd2;

   typedef struct packed {
      logic read_ok;
      logic rx_was_empty;
      logic write_rejected;
      logic rx_dropped;
      logic line_valid;
      logic tx_irq_on;
   } ubrt_flags_type;

endpackage

>>> src/ubrt_ring_mem.sv
// Byte store of one ring: one write port and one registered read port.
// Depends on nothing.
module ubrt_ring_mem #(
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/ubrt_ctrl.sv
// Ring pointers, transmit status and interrupt control of the terminal.
// Depends on ubrt_pkg; drives the ports of both ring stores.
module ubrt_ctrl #(
   parameter int TX_DEPTH = 256,
   parameter int RX_DEPTH = 256,
   localparam int TXW = $clog2(TX_DEPTH),
   localparam int RXW = $clog2(RX_DEPTH)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [1:0]              mode,
   input  logic [7:0]              byte_in,
   output logic                    tx_wr_en,
   output logic [TXW-1:0]          tx_wr_addr,
   output logic                    tx_rd_en,
   output logic [TXW-1:0]          tx_rd_addr,
   output logic                    rx_wr_en,
   output logic [RXW-1:0]          rx_wr_addr,
   output logic                    rx_rd_en,
   output logic [RXW-1:0]          rx_rd_addr,
   output logic [7:0]              wr_data,
   output ubrt_pkg::ubrt_flags_type flags
);

   import ubrt_pkg::*;

   localparam logic [TXW-1:0] TX_LAST = TXW'(TX_DEPTH - 1);
   localparam logic [RXW-1:0] RX_LAST = RXW'(RX_DEPTH - 1);

   logic [TXW-1:0] tx_head_ff, tx_head_in, tx_tail_ff, tx_tail_in;
   logic [RXW-1:0] rx_head_ff, rx_head_in, rx_tail_ff, rx_tail_in;
   logic [1:0]     tx_state_ff, tx_state_in;
   logic           armed_ff, armed_in, irq_ff, irq_in;
   logic [TXW-1:0] tx_head_nxt, tx_tail_nxt;
   logic [RXW-1:0] rx_head_nxt, rx_tail_nxt;

   assign tx_head_nxt = (tx_head_ff == TX_LAST) ? '0 : tx_head_ff + TXW'(1);
   assign tx_tail_nxt = (tx_tail_ff == TX_LAST) ? '0 : tx_tail_ff + TXW'(1);
   assign rx_head_nxt = (rx_head_ff == RX_LAST) ? '0 : rx_head_ff + RXW'(1);
   assign rx_tail_nxt = (rx_tail_ff == RX_LAST) ? '0 : rx_tail_ff + RXW'(1);

   assign tx_wr_addr = tx_head_ff;
   assign tx_rd_addr = tx_tail_ff;
   assign rx_wr_addr = rx_head_ff;
   assign rx_rd_addr = rx_tail_ff;
   assign wr_data    = byte_in;

   always_comb begin
      tx_head_in  = tx_head_ff;
      tx_tail_in  = tx_tail_ff;
      rx_head_in  = rx_head_ff;
      rx_tail_in  = rx_tail_ff;
      tx_state_in = tx_state_ff;
      armed_in    = armed_ff;
      irq_in      = irq_ff;
      tx_wr_en    = 1'b0;
      tx_rd_en    = 1'b0;
      rx_wr_en    = 1'b0;
      rx_rd_en    = 1'b0;
      flags       = '0;
      case (mode)
         MODE_HOST_WRITE: begin
            if (tx_state_ff == TXS_FULL) begin
               flags.write_rejected = 1'b1;
            end else if (tx_head_nxt == tx_tail_ff) begin
               tx_state_in          = TXS_FULL;
               flags.write_rejected = 1'b1;
            end else begin
               tx_wr_en   = 1'b1;
               tx_head_in = tx_head_nxt;
               if (tx_state_ff == TXS_EMPTY) begin
                  if (armed_ff) begin
                     armed_in = 1'b0;
                     irq_in   = 1'b1;
                  end
                  tx_state_in = TXS_NORMAL;
               end
            end
         end
         MODE_HOST_READ: begin
            if (rx_tail_ff != rx_head_ff) begin
               rx_rd_en      = 1'b1;
               rx_tail_in    = rx_tail_nxt;
               flags.read_ok = 1'b1;
            end else begin
               flags.rx_was_empty = 1'b1;
            end
         end
         MODE_LINE_RX: begin
            if (rx_head_nxt == rx_tail_ff) begin
               flags.rx_dropped = 1'b1;
            end else begin
               rx_wr_en   = 1'b1;
               rx_head_in = rx_head_nxt;
            end
         end
         default: begin
            if (irq_ff) begin
               if (tx_head_ff == tx_tail_ff) begin
                  tx_state_in = TXS_EMPTY;
                  armed_in    = 1'b1;
                  irq_in      = 1'b0;
               end else begin
                  tx_rd_en         = 1'b1;
                  tx_tail_in       = tx_tail_nxt;
                  tx_state_in      = TXS_NORMAL;
                  armed_in         = 1'b0;
                  flags.line_valid = 1'b1;
               end
            end
         end
      endcase
      flags.tx_irq_on = irq_in;
      if (!accept) begin
         tx_wr_en = 1'b0;
         tx_rd_en = 1'b0;
         rx_wr_en = 1'b0;
         rx_rd_en = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_head_ff  <= '0;
         tx_tail_ff  <= '0;
         rx_head_ff  <= '0;
         rx_tail_ff  <= '0;
         tx_state_ff <= TXS_EMPTY;
         armed_ff    <= 1'b1;
         irq_ff      <= 1'b0;
      end else if (accept) begin
         tx_head_ff  <= tx_head_in;
         tx_tail_ff  <= tx_tail_in;
         rx_head_ff  <= rx_head_in;
         rx_tail_ff  <= rx_tail_in;
         tx_state_ff <= tx_state_in;
         armed_ff    <= armed_in;
         irq_ff      <= irq_in;
      end
   end

endmodule

>>> src/uart_buffered_rx_tx_rings.sv
// Buffered serial terminal: transmit and receive rings in two byte stores.
// Depends on ubrt_pkg, ubrt_ctrl, ubrt_ring_mem and the assertion header.
// A transferred request is held in stage s1 beside its registered store read; its result
// moves to the output register, which drives rsp_tvalid. One request is taken every
// cycle while the result side keeps up. Reset clears pointers, status and both
// stages; the store contents are left as they are.
`include "uart_buffered_rx_tx_rings_assert.svh"

module uart_buffered_rx_tx_rings #(
   parameter int TX_DEPTH = 256,
   parameter int RX_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // byte_in[7:0]
   input  logic [1:0]  req_tuser,  // mode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_byte[7:0], rx_was_empty[8], write_rejected[9], rx_dropped[10],
   // line_byte[18:11], line_valid[19], tx_irq_on[20], zero[23:21]
   output logic [23:0] rsp_tdata
);

   import ubrt_pkg::*;

   localparam int TXW = $clog2(TX_DEPTH);
   localparam int RXW = $clog2(RX_DEPTH);

   logic           accept, out_free;
   logic           tx_wr_en, tx_rd_en, rx_wr_en, rx_rd_en;
   logic [TXW-1:0] tx_wr_addr, tx_rd_addr;
   logic [RXW-1:0] rx_wr_addr, rx_rd_addr;
   logic [7:0]     wr_data, tx_rd_data, rx_rd_data;
   ubrt_flags_type flags;
   ubrt_flags_type s1_flags_ff;
   logic           s1_valid_ff, s1_valid_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [23:0]    rsp_data_ff, rsp_data_in;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || out_free;
   assign accept     = req_tvalid && req_tready;

   ubrt_ctrl #(
      .TX_DEPTH(TX_DEPTH),
      .RX_DEPTH(RX_DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .mode       (req_tuser),
      .byte_in    (req_tdata),
      .tx_wr_en   (tx_wr_en),
      .tx_wr_addr (tx_wr_addr),
      .tx_rd_en   (tx_rd_en),
      .tx_rd_addr (tx_rd_addr),
      .rx_wr_en   (rx_wr_en),
      .rx_wr_addr (rx_wr_addr),
      .rx_rd_en   (rx_rd_en),
      .rx_rd_addr (rx_rd_addr),
      .wr_data    (wr_data),
      .flags      (flags)
   );

   ubrt_ring_mem #(.DEPTH(TX_DEPTH)) u_tx_mem (
      .clock   (clock),
      .wr_en   (tx_wr_en),
      .wr_addr (tx_wr_addr),
      .wr_data (wr_data),
      .rd_en   (tx_rd_en),
      .rd_addr (tx_rd_addr),
      .rd_data (tx_rd_data)
   );

   ubrt_ring_mem #(.DEPTH(RX_DEPTH)) u_rx_mem (
      .clock   (clock),
      .wr_en   (rx_wr_en),
      .wr_addr (rx_wr_addr),
      .wr_data (wr_data),
      .rd_en   (rx_rd_en),
      .rd_addr (rx_rd_addr),
      .rd_data (rx_rd_data)
   );

   always_comb begin
      s1_valid_in  = accept || (s1_valid_ff && !out_free);
      rsp_valid_in = (s1_valid_ff && out_free) || (rsp_valid_ff && !rsp_tready);
      rsp_data_in  = {3'b000,
                      s1_flags_ff.tx_irq_on,
                      s1_flags_ff.line_valid,
                      s1_flags_ff.line_valid ? tx_rd_data : 8'h00,
                      s1_flags_ff.rx_dropped,
                      s1_flags_ff.write_rejected,
                      s1_flags_ff.rx_was_empty,
                      s1_flags_ff.read_ok ? rx_rd_data : 8'h00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_flags_ff <= flags;
      end
      if (s1_valid_ff && out_free) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `UBRT_ASSERT_NOW(a_line_needs_irq, clock, reset, rsp_tvalid && rsp_tdata[19],
      rsp_tdata[20], "line byte sent with transmit interrupt off")
   `UBRT_ASSERT_NOW(a_empty_read_zero, clock, reset, rsp_tvalid && rsp_tdata[8],
      rsp_tdata[7:0] == 8'h00, "empty read returned data")
   `UBRT_ASSERT_NOW(a_one_event_flag, clock, reset, rsp_tvalid,
      $countones({rsp_tdata[19], rsp_tdata[10:8]}) <= 1, "more than one event flag in a result")
   `UBRT_ASSERT_NEXT(a_stall_holds_stage, clock, reset, s1_valid_ff && !out_free,
      s1_valid_ff, "held stage lost its item")

endmodule

>>> tb/tb_top.sv
// Self-checking bench for uart_buffered_rx_tx_rings: host, line and tick transfers are
// driven in directed and random bursts, and each result is checked against a built-in
// predictor of both rings. Depends on ubrt_pkg and the block's RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ubrt_pkg::*;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] data;
   } host_event_type;

   typedef struct packed {
      logic [2:0] pad;
      logic       tx_irq_on;
      logic       line_valid;
      logic [7:0] line_byte;
      logic       rx_dropped;
      logic       write_rejected;
      logic       rx_was_empty;
      logic [7:0] read_byte;
   } term_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;

   uart_buffered_rx_tx_rings dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   host_event_type  host_events[$];
   term_result_type expected_results[$];
   host_event_type  cur_event;

   logic [7:0] tx_store [256];
   logic [7:0] rx_store [256];
   logic [7:0] tx_wr = '0, tx_rd = '0, rx_wr = '0, rx_rd = '0;
   logic [1:0] tx_ring_mode = TXS_EMPTY;
   logic       direct_ok = 1'b1;
   logic       tx_irq = 1'b0;

   int  accepted_reqs = 0;
   int  checked_results = 0;
   int  error_count = 0;
   int  bytes_sent = 0, host_reads = 0, empty_reads = 0, writes_refused = 0;
   int  line_drops = 0;
   logic stall_hold = 1'b0;
   wire  quiet = (accepted_reqs >= 900) && (accepted_reqs < 1200);

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      error_count++;
      if (error_count <= 40)
         $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
                  checked_results, what, got, want);
   endtask

   task automatic add_event(logic [1:0] mode, logic [7:0] data);
      host_event_type ev;
      ev.mode = mode;
      ev.data = data;
      host_events.push_back(ev);
   endtask

   always @(posedge clock) begin
      term_result_type want;
      logic [7:0]      nxt_slot;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            want = '0;
            accepted_reqs <= accepted_reqs + 1;
            case (cur_event.mode)
               MODE_HOST_WRITE: begin
                  nxt_slot = tx_wr + 8'd1;
                  if (tx_ring_mode == TXS_FULL) begin
                     want.write_rejected = 1'b1;
                  end else if (nxt_slot == tx_rd) begin
                     tx_ring_mode = TXS_FULL;
                     want.write_rejected = 1'b1;
                  end else begin
                     tx_store[tx_wr] = cur_event.data;
                     tx_wr = nxt_slot;
                     if (tx_ring_mode == TXS_EMPTY) begin
                        if (direct_ok) begin
                           direct_ok = 1'b0;
                           tx_irq = 1'b1;
                        end
                        tx_ring_mode = TXS_NORMAL;
                     end
                  end
                  if (want.write_rejected) writes_refused++;
               end
               MODE_HOST_READ: begin
                  host_reads++;
                  if (rx_rd != rx_wr) begin
                     want.read_byte = rx_store[rx_rd];
                     rx_rd = rx_rd + 8'd1;
                  end else begin
                     want.rx_was_empty = 1'b1;
                     empty_reads++;
                  end
               end
               MODE_LINE_RX: begin
                  nxt_slot = rx_wr + 8'd1;
                  if (nxt_slot == rx_rd) begin
                     want.rx_dropped = 1'b1;
                     line_drops++;
                  end else begin
                     rx_store[rx_wr] = cur_event.data;
                     rx_wr = nxt_slot;
                  end
               end
               default: begin
                  if (tx_irq) begin
                     if (tx_wr == tx_rd) begin
                        tx_ring_mode = TXS_EMPTY;
                        direct_ok = 1'b1;
                        tx_irq = 1'b0;
                     end else begin
                        want.line_byte = tx_store[tx_rd];
                        want.line_valid = 1'b1;
                        tx_rd = tx_rd + 8'd1;
                        tx_ring_mode = TXS_NORMAL;
                        direct_ok = 1'b0;
                        bytes_sent++;
                     end
                  end
               end
            endcase
            want.tx_irq_on = tx_irq;
            expected_results.push_back(want);
         end
         if (!req_tvalid || req_tready) begin
            if (host_events.size() != 0 && (quiet || $urandom_range(99) >= 11)) begin
               cur_event = host_events.pop_front();
               req_tdata <= cur_event.data;
               req_tuser <= cur_event.mode;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      term_result_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_results.size() == 0) begin
               report_mismatch("result with nothing pending", got, 0);
            end else begin
               want = expected_results.pop_front();
               if (got.read_byte != want.read_byte)
                  report_mismatch("read_byte", got.read_byte, want.read_byte);
               if (got.rx_was_empty != want.rx_was_empty)
                  report_mismatch("rx_was_empty", got.rx_was_empty, want.rx_was_empty);
               if (got.write_rejected != want.write_rejected)
                  report_mismatch("write_rejected", got.write_rejected, want.write_rejected);
               if (got.rx_dropped != want.rx_dropped)
                  report_mismatch("rx_dropped", got.rx_dropped, want.rx_dropped);
               if (got.line_byte != want.line_byte)
                  report_mismatch("line_byte", got.line_byte, want.line_byte);
               if (got.line_valid != want.line_valid)
                  report_mismatch("line_valid", got.line_valid, want.line_valid);
               if (got.tx_irq_on != want.tx_irq_on)
                  report_mismatch("tx_irq_on", got.tx_irq_on, want.tx_irq_on);
               if (got.pad != want.pad)
                  report_mismatch("unused bits", got.pad, want.pad);
            end
            checked_results++;
         end
         rsp_tready <= !stall_hold && (quiet || $urandom_range(99) >= 11);
      end
   end

   initial begin
      wait (accepted_reqs >= 400);
      @(posedge clock);
      stall_hold <= 1'b1;
      repeat (300) @(posedge clock);
      stall_hold <= 1'b0;
   end

   initial begin
      int          ep, kind, len;
      logic [1:0]  mode;
      add_event(MODE_TX_TICK, 8'h3C);
      add_event(MODE_HOST_READ, 8'h00);
      add_event(MODE_HOST_WRITE, 8'h00);
      add_event(MODE_HOST_WRITE, 8'hFF);
      add_event(MODE_HOST_WRITE, 8'hA5);
      add_event(MODE_TX_TICK, 8'h00);
      add_event(MODE_TX_TICK, 8'hFF);
      add_event(MODE_TX_TICK, 8'h00);
      add_event(MODE_TX_TICK, 8'h00);
      add_event(MODE_TX_TICK, 8'h00);
      add_event(MODE_LINE_RX, 8'h00);
      add_event(MODE_LINE_RX, 8'hFF);
      add_event(MODE_LINE_RX, 8'h5A);
      add_event(MODE_HOST_READ, 8'hFF);
      add_event(MODE_HOST_READ, 8'h00);
      add_event(MODE_HOST_READ, 8'h00);
      add_event(MODE_HOST_READ, 8'h00);
      add_event(MODE_HOST_WRITE, 8'h81);
      add_event(MODE_TX_TICK, 8'h00);
      add_event(MODE_HOST_WRITE, 8'h7E);
      add_event(MODE_TX_TICK, 8'h00);
      add_event(MODE_TX_TICK, 8'h00);
      add_event(MODE_TX_TICK, 8'h00);

      ep = 0;
      while (host_events.size() < 1800) begin
         kind = (ep < 5) ? ep : $urandom_range(4);
         case (kind)
            1: len = $urandom_range(290, 250);
            2: len = $urandom_range(300, 10);
            3: len = $urandom_range(290, 250);
            4: len = $urandom_range(300, 10);
            default: len = $urandom_range(60, 20);
         endcase
         if (len > 1800 - host_events.size())
            len = 1800 - host_events.size();
         repeat (len) begin
            case (kind)
               1: mode = ($urandom_range(99) < 5) ? MODE_TX_TICK : MODE_HOST_WRITE;
               2: mode = ($urandom_range(99) < 10) ? MODE_HOST_WRITE : MODE_TX_TICK;
               3: mode = ($urandom_range(99) < 5) ? MODE_HOST_READ : MODE_LINE_RX;
               4: mode = ($urandom_range(99) < 10) ? MODE_LINE_RX : MODE_HOST_READ;
               default: mode = 2'($urandom_range(3));
            endcase
            add_event(mode, 8'($urandom_range(255)));
         end
         ep++;
      end

      wait (!reset);
      while (host_events.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (expected_results.size() != 0)
         report_mismatch("results never delivered", expected_results.size(), 0);
      $display("Ran %0d transfers in; %0d results checked.", accepted_reqs, checked_results);
      $display("Line bytes sent %0d, host reads %0d (%0d empty), writes refused %0d, drops %0d.",
               bytes_sent, host_reads, empty_reads, writes_refused, line_drops);
      if (error_count == 0) begin
         $display("PASS uart_buffered_rx_tx_rings");
      end else begin
         $display("FAIL uart_buffered_rx_tx_rings");
      end
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #1000000;
      $display("FAIL uart_buffered_rx_tx_rings");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+src
src/ubrt_pkg.sv
src/ubrt_ring_mem.sv
src/ubrt_ctrl.sv
src/uart_buffered_rx_tx_rings.sv
tb/tb_top.sv
